// ===== rtl/rna_pkg.sv =====
// Package for the rational number ALU: widths, command and status codes,
// and the job record passed from the front end to the back end. No dependencies.
package rna_pkg;
    localparam int W  = 32;
    localparam int DW = 2 * W;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [2:0] {
        CMD_NORM = 3'd0, CMD_ADD = 3'd1, CMD_SUB = 3'd2, CMD_MUL = 3'd3,
        CMD_DIV  = 3'd4, CMD_CMP = 3'd5, CMD_NEG = 3'd6, CMD_NORM7 = 3'd7
    } cmd_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Operand magnitudes and signs, classified by the front end.
    typedef struct packed {
        cmd_t          cmd;
        logic          err;
        logic          an_s;
        logic          ad_s;
        logic          bn_s;
        logic          bd_s;
        logic [W-1:0]  an;
        logic [W-1:0]  ad;
        logic [W-1:0]  bn;
        logic [W-1:0]  bd;
    } job_t;

    typedef enum logic [3:0] {
        BS_IDLE, BS_M1, BS_M2, BS_M3, BS_COMB, BS_GLOAD, BS_GCD,
        BS_DINIT, BS_DIV, BS_DNEXT, BS_OUT
    } bstate_t;
endpackage

// ===== rtl/rna_front.sv =====
// Front end of the rational number ALU: takes a command transaction and
// splits the operands into signs and magnitudes. Depends on rna_pkg.
module rna_front
    import rna_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [2:0]   cmd,
    input  logic [31:0]  a_num,
    input  logic [31:0]  a_den,
    input  logic [31:0]  b_num,
    input  logic [31:0]  b_den,
    input  logic         q_full,
    output logic         busy,
    output logic         push,
    output job_t         job
);
    logic  take;
    logic  bin;
    cmd_t  c;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign busy = q_full;
    assign take = start && !busy;
    assign c    = cmd_t'(cmd);
    assign bin  = (c == CMD_ADD) || (c == CMD_SUB) || (c == CMD_MUL) ||
                  (c == CMD_DIV) || (c == CMD_CMP);

    always_comb
    begin
        job.cmd  = c;
        job.an   = mag(a_num[W-1:0]);
        job.ad   = mag(a_den[W-1:0]);
        job.bn   = mag(b_num[W-1:0]);
        job.bd   = mag(b_den[W-1:0]);
        job.an_s = a_num[W-1];
        job.ad_s = a_den[W-1];
        job.bn_s = b_num[W-1];
        job.bd_s = b_den[W-1];
        job.err  = (a_den[W-1:0] == '0) || (bin && b_den[W-1:0] == '0) ||
                   (c == CMD_DIV && b_num[W-1:0] == '0);
    end

    assign push = take;

    logic took_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            took_reg <= 1'b0;
        else
            took_reg <= take;
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) took_reg |-> $past(start))
        else $error("transaction without start");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !q_full) |-> push)
        else $error("accepted transaction not pushed");
endmodule

// ===== rtl/rna_queue.sv =====
// Two-entry job queue between the front and back ends. Depends on rna_pkg.
module rna_queue
    import rna_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t dout
);
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (wp_reg == rp_reg))
        else $error("empty queue with unequal pointers");
endmodule

// ===== rtl/rna_back.sv =====
// Back end of the rational number ALU: cross products, binary GCD, and
// restoring division by the GCD. Depends on rna_pkg.
module rna_back
    import rna_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  job_t          job,
    output logic          pop,
    output logic          done,
    output logic [31:0]   res_num,
    output logic [30:0]   res_den,
    output logic [1:0]    status,
    output logic          is_greater,
    output logic          is_equal,
    output logic          is_less
);
    bstate_t st_reg, st_next;
    job_t    j_reg;
    logic [DW-1:0] p_reg [3];
    logic [DW-1:0] n_reg, d_reg, gx_reg, gy_reg;
    logic [DW-1:0] rem_reg, quo_reg, dvd_reg;
    logic [CW-1:0] k_reg, cnt_reg;
    logic          neg_reg, which_reg;
    logic [31:0]   rn_reg;
    logic [30:0]   rd_reg;
    logic [1:0]    rs_reg;
    logic          gt_reg, eq_reg, lt_reg, done_reg;

    logic          sa, sb;
    logic [W-1:0]  ma, mb;
    logic [DW-1:0] prod;
    logic [DW:0]   trial;
    logic [DW-1:0] lim;

    assign sa = j_reg.an_s ^ j_reg.ad_s;
    assign sb = j_reg.bn_s ^ j_reg.bd_s;
    assign lim = DW'(1) << (W - 1);

    // One multiplier, shared over the three steps BS_M1, BS_M2 and BS_M3.
    always_comb
    begin
        unique case (st_reg)
            BS_M1:   begin ma = (j_reg.cmd == CMD_MUL) ? j_reg.bn : j_reg.bd; mb = j_reg.an; end
            BS_M2:   begin ma = j_reg.bn; mb = (j_reg.cmd == CMD_MUL) ? j_reg.an : j_reg.ad; end
            default: begin ma = (j_reg.cmd == CMD_DIV) ? j_reg.bn : j_reg.bd; mb = j_reg.ad; end
        endcase
        if (st_reg == BS_M2 && j_reg.cmd == CMD_MUL)
            begin ma = j_reg.bd; mb = j_reg.ad; end
        prod = DW'(ma) * DW'(mb);
    end

    assign trial = {rem_reg, dvd_reg[DW-1]} - {1'b0, gx_reg};

    always_comb
    begin
        st_next = st_reg;
        pop     = 1'b0;
        unique case (st_reg)
            BS_IDLE:  if (!q_empty) begin pop = 1'b1; st_next = BS_M1; end
            BS_M1:    st_next = j_reg.err ? BS_OUT : BS_M2;
            BS_M2:    st_next = BS_M3;
            BS_M3:    st_next = BS_COMB;
            BS_COMB:  st_next = (j_reg.cmd == CMD_CMP) ? BS_OUT : BS_GLOAD;
            BS_GLOAD: st_next = BS_GCD;
            BS_GCD:   if (gx_reg == '0) st_next = BS_DINIT;
            BS_DINIT: st_next = BS_DIV;
            BS_DIV:   if (cnt_reg == CW'(1)) st_next = which_reg ? BS_OUT : BS_DNEXT;
            BS_DNEXT: st_next = BS_DIV;
            BS_OUT:   st_next = BS_IDLE;
            default:  st_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == BS_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            BS_IDLE: j_reg <= job;
            BS_M1:   p_reg[0] <= prod;
            BS_M2:   p_reg[1] <= prod;
            BS_M3:   p_reg[2] <= prod;
            BS_COMB:
            begin
                // p0 = an*bd, p1 = bn*ad, p2 = ad*bd (per command)
                logic s2;
                s2 = (j_reg.cmd == CMD_SUB) ? !sb : sb;
                if (j_reg.bn == '0) s2 = 1'b0;
                gt_reg <= 1'b0; eq_reg <= 1'b0; lt_reg <= 1'b0;
                d_reg  <= p_reg[2];
                unique case (j_reg.cmd)
                    CMD_ADD, CMD_SUB:
                    begin
                        if ((sa && j_reg.an != '0) == s2)
                            begin n_reg <= p_reg[0] + p_reg[1]; neg_reg <= sa && j_reg.an != '0; end
                        else if (p_reg[0] >= p_reg[1])
                            begin n_reg <= p_reg[0] - p_reg[1]; neg_reg <= sa && j_reg.an != '0; end
                        else
                            begin n_reg <= p_reg[1] - p_reg[0]; neg_reg <= s2; end
                    end
                    CMD_MUL:
                    begin
                        n_reg <= p_reg[0]; d_reg <= p_reg[1];
                        neg_reg <= (sa && j_reg.an != '0) != (sb && j_reg.bn != '0);
                    end
                    CMD_DIV:
                    begin
                        n_reg <= p_reg[0]; d_reg <= p_reg[2];
                        neg_reg <= (sa && j_reg.an != '0) != (sb && j_reg.bn != '0);
                    end
                    CMD_CMP:
                    begin
                        logic nl, nr;
                        nl = sa && j_reg.an != '0;
                        nr = sb && j_reg.bn != '0;
                        eq_reg <= (nl == nr) && (p_reg[0] == p_reg[1]);
                        gt_reg <= (!nl && nr && !(p_reg[0] == '0 && p_reg[1] == '0)) ||
                                  (!nl && !nr && p_reg[0] > p_reg[1]) ||
                                  (nl && nr && p_reg[0] < p_reg[1]);
                        lt_reg <= (nl && !nr && !(p_reg[0] == '0 && p_reg[1] == '0)) ||
                                  (nl && nr && p_reg[0] > p_reg[1]) ||
                                  (!nl && !nr && p_reg[0] < p_reg[1]);
                    end
                    CMD_NEG:
                    begin
                        n_reg <= DW'(j_reg.an); d_reg <= DW'(j_reg.ad);
                        neg_reg <= !(sa && j_reg.an != '0);
                    end
                    default:
                    begin
                        n_reg <= DW'(j_reg.an); d_reg <= DW'(j_reg.ad);
                        neg_reg <= sa && j_reg.an != '0;
                    end
                endcase
            end
            BS_GLOAD:
            begin
                gx_reg <= n_reg; gy_reg <= d_reg; k_reg <= '0;
            end
            BS_GCD:
            begin
                // Binary GCD: common factors of two are counted in k_reg and put
                // back when the divisor is formed.
                if (gx_reg != '0)
                begin
                    if (!gx_reg[0] && !gy_reg[0])
                    begin
                        gx_reg <= gx_reg >> 1; gy_reg <= gy_reg >> 1;
                        k_reg  <= k_reg + CW'(1);
                    end
                    else if (!gx_reg[0])
                        gx_reg <= gx_reg >> 1;
                    else if (!gy_reg[0])
                        gy_reg <= gy_reg >> 1;
                    else if (gx_reg >= gy_reg)
                        gx_reg <= gx_reg - gy_reg;
                    else
                        gy_reg <= gy_reg - gx_reg;
                end
            end
            BS_DINIT:
            begin
                gx_reg <= (gy_reg == '0) ? DW'(1) : (gy_reg << k_reg);
                rem_reg <= '0; dvd_reg <= n_reg; cnt_reg <= CW'(DW);
                which_reg <= 1'b0;
            end
            BS_DIV:
            begin
                if (!trial[DW])
                    begin rem_reg <= trial[DW-1:0]; quo_reg <= {quo_reg[DW-2:0], 1'b1}; end
                else
                    begin rem_reg <= {rem_reg[DW-2:0], dvd_reg[DW-1]}; quo_reg <= {quo_reg[DW-2:0], 1'b0}; end
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                cnt_reg <= cnt_reg - CW'(1);
            end
            BS_DNEXT:
            begin
                n_reg <= quo_reg; rem_reg <= '0; dvd_reg <= d_reg;
                cnt_reg <= CW'(DW); which_reg <= 1'b1;
            end
            BS_OUT:
            begin
                logic [DW-1:0] qn, qd;
                logic          ng;
                qn = n_reg; qd = (j_reg.cmd == CMD_CMP || j_reg.err) ? '0 : quo_reg;
                ng = neg_reg;
                if (qn == '0) begin ng = 1'b0; qd = DW'(1); end
                rs_reg <= ST_OK; rn_reg <= '0; rd_reg <= '0;
                if (j_reg.err)
                    begin rs_reg <= ST_ZDEN; gt_reg <= 1'b0; eq_reg <= 1'b0; lt_reg <= 1'b0; end
                else if (j_reg.cmd != CMD_CMP)
                begin
                    if (qd > lim - 1 || qn > (ng ? lim : lim - 1))
                        rs_reg <= ST_OVF;
                    else
                    begin
                        rn_reg <= 32'(ng ? (~qn + 1'b1) : qn);
                        rd_reg <= 31'(qd);
                    end
                end
            end
            default: ;
        endcase
    end

    assign done       = done_reg;
    assign res_num    = done_reg ? rn_reg : '0;
    assign res_den    = done_reg ? rd_reg : '0;
    assign status     = done_reg ? rs_reg : ST_OK;
    assign is_greater = done_reg && gt_reg && rs_reg == ST_OK && j_reg.cmd == CMD_CMP;
    assign is_equal   = done_reg && eq_reg && rs_reg == ST_OK && j_reg.cmd == CMD_CMP;
    assign is_less    = done_reg && lt_reg && rs_reg == ST_OK && j_reg.cmd == CMD_CMP;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(st_reg == BS_OUT))
        else $error("result strobe without final step");
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> st_reg == BS_M1)
        else $error("job popped but not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({is_greater, is_equal, is_less}))
        else $error("compare flags not exclusive");
endmodule

// ===== rtl/rational_number_alu.sv =====
// Rational number ALU top level: front end, two-entry queue, back end.
// A fraction result passes through the cross products, the binary GCD steps and two
// restoring divisions; compare skips GCD and division, a zero denominator goes to output.
// Up to two more transactions are queued while one executes; busy rises when full.
// Reset is asynchronous, active low, and empties the queue and idles the back end.
// Results appear for one cycle with done high; the receiver cannot stall them.
module rational_number_alu
    import rna_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [2:0]   cmd,
    input  logic [31:0]  a_num,
    input  logic [31:0]  a_den,
    input  logic [31:0]  b_num,
    input  logic [31:0]  b_den,
    output logic         done,
    output logic [31:0]  res_num,
    output logic [30:0]  res_den,
    output logic [1:0]   status,
    output logic         is_greater,
    output logic         is_equal,
    output logic         is_less
);
    // Transactions flow front -> queue -> back.
    job_t fjob, qjob;
    logic push, pop, full, empty;

    rna_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .q_full(full), .busy(busy), .push(push), .job(fjob)
    );

    rna_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .din(fjob),
        .pop(pop), .full(full), .empty(empty), .dout(qjob)
    );

    rna_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(empty), .job(qjob), .pop(pop),
        .done(done), .res_num(res_num), .res_den(res_den), .status(status),
        .is_greater(is_greater), .is_equal(is_equal), .is_less(is_less)
    );
endmodule
